// ===== rtl/triangle_element_stiffness_top_defines.svh =====
// Assertion macros used by the triangle stiffness top level.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_TOP_DEFINES_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on aclk outside reset.
`define CST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on aclk outside reset.
`define CST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CST_ASSERT_IMP(lbl, ante, cons, msg)
`define CST_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cst_pkg.sv =====
// Package: shared constants and types of the triangle stiffness block.
`default_nettype none
package cst_pkg;
    localparam int LIMB_W    = 32;
    localparam int D_W       = 32;
    localparam int VAL_W     = 64;
    localparam int Q_BITS    = 64;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = 3'd5;
    localparam logic [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

    // Material register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_D_XX = 3'd0,
        REG_D_XY = 3'd1,
        REG_D_XS = 3'd2,
        REG_D_YY = 3'd3,
        REG_D_YS = 3'd4,
        REG_D_SS = 3'd5
    } cfg_reg_t;

    // Sideband that travels with each matrix entry
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             degen;
        logic             neg;
        logic             ovf;
    } cst_side_t;
endpackage
`default_nettype wire

// ===== rtl/cst_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, with rounding remainder.
`default_nettype none
module cst_div #(
    parameter int DEN_W = 68
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_vld,
    input  wire cst_pkg::cst_side_t         in_side,
    input  wire logic [DEN_W-1:0]           in_den,
    input  wire logic [DEN_W-1:0]           in_rem,
    input  wire logic [cst_pkg::Q_BITS-1:0] in_lq,
    output logic                            out_vld,
    output cst_pkg::cst_side_t              out_side,
    output logic [DEN_W-1:0]                out_den,
    output logic [DEN_W-1:0]                out_rem,
    output logic [cst_pkg::Q_BITS-1:0]      out_quo
);
    localparam int QB = cst_pkg::Q_BITS;

    logic                  vld_reg  [1:QB];
    cst_pkg::cst_side_t    side_reg [1:QB];
    logic [DEN_W-1:0]      den_reg  [1:QB];
    logic [DEN_W-1:0]      rem_reg  [1:QB];
    logic [QB-1:0]         lq_reg   [1:QB];
    logic                  vld_next  [1:QB];
    cst_pkg::cst_side_t    side_next [1:QB];
    logic [DEN_W-1:0]      den_next  [1:QB];
    logic [DEN_W-1:0]      rem_next  [1:QB];
    logic [QB-1:0]         lq_next   [1:QB];

    // Each stage shifts in one dividend bit and subtracts when it fits
    always_comb begin
        logic                 cur_vld;
        cst_pkg::cst_side_t   cur_side;
        logic [DEN_W-1:0]     cur_den;
        logic [DEN_W-1:0]     cur_rem;
        logic [QB-1:0]        cur_lq;
        logic [DEN_W:0]       trial;
        logic                 fits;
        for (int s = 0; s < QB; s++) begin
            if (s == 0) begin
                cur_vld  = in_vld;
                cur_side = in_side;
                cur_den  = in_den;
                cur_rem  = in_rem;
                cur_lq   = in_lq;
            end else begin
                cur_vld  = vld_reg[s];
                cur_side = side_reg[s];
                cur_den  = den_reg[s];
                cur_rem  = rem_reg[s];
                cur_lq   = lq_reg[s];
            end
            trial = {cur_rem, cur_lq[QB-1]};
            fits  = (trial >= {1'b0, cur_den});
            if (fits) begin
                trial = trial - {1'b0, cur_den};
            end
            vld_next[s+1]  = cur_vld;
            side_next[s+1] = cur_side;
            den_next[s+1]  = cur_den;
            rem_next[s+1]  = trial[DEN_W-1:0];
            lq_next[s+1]   = {cur_lq[QB-2:0], fits};
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        for (int s = 1; s <= QB; s++) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_next[s];
            end
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 1; s <= QB; s++) begin
                side_reg[s] <= side_next[s];
                den_reg[s]  <= den_next[s];
                rem_reg[s]  <= rem_next[s];
                lq_reg[s]   <= lq_next[s];
            end
        end
    end

    assign out_vld  = vld_reg[QB];
    assign out_side = side_reg[QB];
    assign out_den  = den_reg[QB];
    assign out_rem  = rem_reg[QB];
    assign out_quo  = lq_reg[QB];
endmodule
`default_nettype wire

// ===== rtl/triangle_element_stiffness_top.sv =====
// Top level: constant-strain triangle element stiffness pipeline.
//
// Usage:
//   A request on the s_ channel carries three corners (signed, FRAC_BITS
//   fraction bits) and a thickness. The block answers with 36 entries of the
//   6x6 stiffness matrix on the m_ channel, row-major, m_last on the final one.
//   The material matrix is written through cfg_wr_en/cfg_index/cfg_wdata
//   while the block is idle; indexes 6 and 7 are ignored.
// Throughput and structure:
//   Entries leave one per cycle while m_ready does not hold the pipeline. An
//   issue counter walks the 36 entries of one request, so a new request is
//   taken only as the last entry of the previous one issues.
//   The path is nine arithmetic stages, a 64-stage divider (one quotient bit
//   per stage) and an output register.
// Reset and stall:
//   aresetn (synchronous, active low) clears all valid bits, the issue
//   counter and the material registers. When m_valid is high and m_ready
//   is low the whole pipeline holds; nothing is lost or repeated.
`default_nettype none
`include "triangle_element_stiffness_top_defines.svh"
module triangle_element_stiffness_top #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [COORD_BITS-1:0]        s_ax,
    input  wire logic signed [COORD_BITS-1:0]        s_ay,
    input  wire logic signed [COORD_BITS-1:0]        s_bx,
    input  wire logic signed [COORD_BITS-1:0]        s_by_coord,
    input  wire logic signed [COORD_BITS-1:0]        s_cx,
    input  wire logic signed [COORD_BITS-1:0]        s_cy,
    input  wire logic [COORD_BITS-2:0]               s_thick,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cst_pkg::IDX_W-1:0]                m_row_idx,
    output logic [cst_pkg::IDX_W-1:0]                m_col_idx,
    output logic signed [cst_pkg::VAL_W-1:0]         m_value,
    output logic                                     m_degenerate,
    output logic                                     m_last,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cst_pkg::D_W-1:0]             cfg_wdata
);
    localparam int LW     = cst_pkg::LIMB_W;
    localparam int QB     = cst_pkg::Q_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int TH_W   = COORD_BITS - 1;
    localparam int DET_W  = 2 * DIFF_W + 1;
    localparam int FS     = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int FL     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int DEN_W  = DET_W + 1 + FS;
    localparam int PD_W   = cst_pkg::D_W + DIFF_W;
    localparam int S_W    = PD_W + 2;
    localparam int SC     = (S_W + LW - 1) / LW;
    localparam int SP_W   = SC * LW;
    localparam int PP_W   = DIFF_W + LW + 1;
    localparam int T_W    = S_W + DIFF_W;
    localparam int N_W    = T_W + 2;
    localparam int NC     = (N_W + LW - 1) / LW;
    localparam int NP_W   = NC * LW;
    localparam int TP_W   = LW + 1 + COORD_BITS;
    localparam int P_W    = N_W + TH_W + 1;
    localparam int MAGR_W = P_W + FL;
    localparam int MAG_W  = (MAGR_W > QB) ? MAGR_W : QB + 1;
    localparam int HI_W   = MAG_W - QB;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

    // ------------------------------------------------------------------
    // Material registers
    logic signed [cst_pkg::D_W-1:0] d_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                d_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cst_pkg::REG_D_XX: d_reg[cst_pkg::REG_D_XX] <= cfg_wdata;
                cst_pkg::REG_D_XY: d_reg[cst_pkg::REG_D_XY] <= cfg_wdata;
                cst_pkg::REG_D_XS: d_reg[cst_pkg::REG_D_XS] <= cfg_wdata;
                cst_pkg::REG_D_YY: d_reg[cst_pkg::REG_D_YY] <= cfg_wdata;
                cst_pkg::REG_D_YS: d_reg[cst_pkg::REG_D_YS] <= cfg_wdata;
                cst_pkg::REG_D_SS: d_reg[cst_pkg::REG_D_SS] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Expand the symmetric material matrix
    logic signed [cst_pkg::D_W-1:0] dm [3][3];
    always_comb begin
        dm[0][0] = d_reg[cst_pkg::REG_D_XX];
        dm[0][1] = d_reg[cst_pkg::REG_D_XY];
        dm[0][2] = d_reg[cst_pkg::REG_D_XS];
        dm[1][0] = d_reg[cst_pkg::REG_D_XY];
        dm[1][1] = d_reg[cst_pkg::REG_D_YY];
        dm[1][2] = d_reg[cst_pkg::REG_D_YS];
        dm[2][0] = d_reg[cst_pkg::REG_D_XS];
        dm[2][1] = d_reg[cst_pkg::REG_D_YS];
        dm[2][2] = d_reg[cst_pkg::REG_D_SS];
    end

    // ------------------------------------------------------------------
    // Global advance: the pipeline moves when the output register is empty or being taken
    logic adv;
    logic accept;
    logic busy_reg;
    logic [cst_pkg::IDX_W-1:0] row_reg, col_reg;
    logic last_issue;

    assign adv        = !m_valid || m_ready;
    assign last_issue = (row_reg == cst_pkg::LAST_IDX) && (col_reg == cst_pkg::LAST_IDX);
    assign s_ready    = !busy_reg || (adv && last_issue);
    assign accept     = s_valid && s_ready;

    // Hold the coordinate differences of the request being issued
    logic signed [DIFF_W-1:0] x12_reg, y12_reg, x13_reg, y13_reg, x23_reg, y23_reg;
    logic [TH_W-1:0]          th_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            x12_reg <= DIFF_W'(s_ax) - DIFF_W'(s_bx);
            y12_reg <= DIFF_W'(s_ay) - DIFF_W'(s_by_coord);
            x13_reg <= DIFF_W'(s_ax) - DIFF_W'(s_cx);
            y13_reg <= DIFF_W'(s_ay) - DIFF_W'(s_cy);
            x23_reg <= DIFF_W'(s_bx) - DIFF_W'(s_cx);
            y23_reg <= DIFF_W'(s_by_coord) - DIFF_W'(s_cy);
            th_reg  <= s_thick;
        end
    end

    // Walk the 36 entries row-major
    logic                      busy_next;
    logic [cst_pkg::IDX_W-1:0] row_next, col_next;

    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (busy_reg && adv) begin
            if (col_reg == cst_pkg::LAST_IDX) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            if (last_issue) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
            row_next  = '0;
            col_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    // Pick the strain-displacement columns for the current row and column
    logic signed [DIFF_W-1:0] bnj [3];
    logic signed [DIFF_W-1:0] bni [3];

    always_comb begin
        bnj[0] = '0;
        bnj[1] = '0;
        bnj[2] = '0;
        case (col_reg)
            3'd0: begin bnj[0] = y23_reg;  bnj[2] = -x23_reg; end
            3'd1: begin bnj[1] = -x23_reg; bnj[2] = y23_reg;  end
            3'd2: begin bnj[0] = -y13_reg; bnj[2] = x13_reg;  end
            3'd3: begin bnj[1] = x13_reg;  bnj[2] = -y13_reg; end
            3'd4: begin bnj[0] = y12_reg;  bnj[2] = -x12_reg; end
            3'd5: begin bnj[1] = -x12_reg; bnj[2] = y12_reg;  end
            default: ;
        endcase
    end

    always_comb begin
        bni[0] = '0;
        bni[1] = '0;
        bni[2] = '0;
        case (row_reg)
            3'd0: begin bni[0] = y23_reg;  bni[2] = -x23_reg; end
            3'd1: begin bni[1] = -x23_reg; bni[2] = y23_reg;  end
            3'd2: begin bni[0] = -y13_reg; bni[2] = x13_reg;  end
            3'd3: begin bni[1] = x13_reg;  bni[2] = -y13_reg; end
            3'd4: begin bni[0] = y12_reg;  bni[2] = -x12_reg; end
            3'd5: begin bni[1] = -x12_reg; bni[2] = y12_reg;  end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Valid bits of stages 1..9
    logic vld_reg [1:9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= 9; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[1] <= busy_reg;
            for (int s = 2; s <= 9; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Stage 1: material times column products, determinant products
    logic signed [PD_W-1:0]     s1_pd_reg [3][3];
    logic signed [PD_W-1:0]     s1_pd_next [3][3];
    logic signed [2*DIFF_W-1:0] s1_dp_reg, s1_dn_reg;
    logic signed [DIFF_W-1:0]   s1_bni_reg [3];
    logic [TH_W-1:0]            s1_th_reg;
    cst_pkg::cst_side_t         s1_side_reg, s1_side_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                s1_pd_next[k][m] = PD_W'(dm[k][m] * bnj[m]);
            end
        end
        s1_side_next       = '0;
        s1_side_next.row   = row_reg;
        s1_side_next.col   = col_reg;
        s1_side_next.last  = last_issue;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pd_reg   <= s1_pd_next;
            s1_dp_reg   <= (2*DIFF_W)'(x13_reg * y23_reg);
            s1_dn_reg   <= (2*DIFF_W)'(x23_reg * y13_reg);
            s1_bni_reg  <= bni;
            s1_th_reg   <= th_reg;
            s1_side_reg <= s1_side_next;
        end
    end

    // Stage 2: sum to the D*B column, form determinant and divisor
    logic signed [S_W-1:0]    s2_s_reg [3];
    logic signed [S_W-1:0]    s2_s_next [3];
    logic [DEN_W-1:0]         s2_den_reg, s2_den_next;
    logic signed [DIFF_W-1:0] s2_bni_reg [3];
    logic [TH_W-1:0]          s2_th_reg;
    cst_pkg::cst_side_t       s2_side_reg, s2_side_next;
    logic signed [DET_W-1:0]  det;
    logic [DET_W-1:0]         det_abs;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s2_s_next[k] = S_W'(s1_pd_reg[k][0]) + S_W'(s1_pd_reg[k][1])
                         + S_W'(s1_pd_reg[k][2]);
        end
        det          = DET_W'(s1_dp_reg) - DET_W'(s1_dn_reg);
        det_abs      = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
        s2_den_next  = DEN_W'(det_abs) << (1 + FS);
        s2_side_next = s1_side_reg;
        s2_side_next.degen = (det == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_s_reg    <= s2_s_next;
            s2_den_reg  <= s2_den_next;
            s2_bni_reg  <= s1_bni_reg;
            s2_th_reg   <= s1_th_reg;
            s2_side_reg <= s2_side_next;
        end
    end

    // Stage 3: row entry times 32-bit slices of the D*B column
    logic signed [PP_W-1:0] s3_pp_reg [3][SC];
    logic signed [PP_W-1:0] s3_pp_next [3][SC];
    logic [DEN_W-1:0]       s3_den_reg;
    logic [TH_W-1:0]        s3_th_reg;
    cst_pkg::cst_side_t     s3_side_reg;

    always_comb begin
        logic signed [SP_W-1:0] s_ext;
        logic [LW:0]            slice;
        for (int k = 0; k < 3; k++) begin
            s_ext = SP_W'(s2_s_reg[k]);
            for (int c = 0; c < SC; c++) begin
                if (c == SC - 1) begin
                    slice = {s_ext[SP_W-1], s_ext[c*LW +: LW]};
                end else begin
                    slice = {1'b0, s_ext[c*LW +: LW]};
                end
                s3_pp_next[k][c] = PP_W'(s2_bni_reg[k] * $signed(slice));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_pp_reg   <= s3_pp_next;
            s3_den_reg  <= s2_den_reg;
            s3_th_reg   <= s2_th_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // Stage 4: recombine slices per row term
    logic signed [T_W-1:0] s4_t_reg [3];
    logic signed [T_W-1:0] s4_t_next [3];
    logic [DEN_W-1:0]      s4_den_reg;
    logic [TH_W-1:0]       s4_th_reg;
    cst_pkg::cst_side_t    s4_side_reg;

    always_comb begin
        logic signed [T_W-1:0] acc;
        for (int k = 0; k < 3; k++) begin
            acc = '0;
            for (int c = 0; c < SC; c++) begin
                acc = acc + (T_W'(s3_pp_reg[k][c]) << (c * LW));
            end
            s4_t_next[k] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_t_reg    <= s4_t_next;
            s4_den_reg  <= s3_den_reg;
            s4_th_reg   <= s3_th_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // Stage 5: entry of B^T*D*B (unscaled)
    logic signed [N_W-1:0] s5_n_reg, s5_n_next;
    logic [DEN_W-1:0]      s5_den_reg;
    logic [TH_W-1:0]       s5_th_reg;
    cst_pkg::cst_side_t    s5_side_reg;

    assign s5_n_next = N_W'(s4_t_reg[0]) + N_W'(s4_t_reg[1]) + N_W'(s4_t_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_n_reg    <= s5_n_next;
            s5_den_reg  <= s4_den_reg;
            s5_th_reg   <= s4_th_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // Stage 6: thickness times 32-bit slices of the entry
    logic signed [TP_W-1:0] s6_tp_reg [NC];
    logic signed [TP_W-1:0] s6_tp_next [NC];
    logic [DEN_W-1:0]       s6_den_reg;
    cst_pkg::cst_side_t     s6_side_reg;

    always_comb begin
        logic signed [NP_W-1:0] n_ext;
        logic [LW:0]            slice;
        n_ext = NP_W'(s5_n_reg);
        for (int c = 0; c < NC; c++) begin
            if (c == NC - 1) begin
                slice = {n_ext[NP_W-1], n_ext[c*LW +: LW]};
            end else begin
                slice = {1'b0, n_ext[c*LW +: LW]};
            end
            s6_tp_next[c] = TP_W'($signed(slice) * $signed({1'b0, s5_th_reg}));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_tp_reg   <= s6_tp_next;
            s6_den_reg  <= s5_den_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // Stage 7: recombine the scaled entry
    logic signed [P_W-1:0] s7_p_reg, s7_p_next;
    logic [DEN_W-1:0]      s7_den_reg;
    cst_pkg::cst_side_t    s7_side_reg;

    always_comb begin
        s7_p_next = '0;
        for (int c = 0; c < NC; c++) begin
            s7_p_next = s7_p_next + (P_W'(s6_tp_reg[c]) << (c * LW));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_p_reg    <= s7_p_next;
            s7_den_reg  <= s6_den_reg;
            s7_side_reg <= s6_side_reg;
        end
    end

    // Stage 8: split into sign and magnitude
    logic [MAG_W-1:0]   s8_mag_reg, s8_mag_next;
    logic [DEN_W-1:0]   s8_den_reg;
    cst_pkg::cst_side_t s8_side_reg, s8_side_next;
    logic [P_W-1:0]     p_abs;

    always_comb begin
        p_abs        = s7_p_reg[P_W-1] ? P_W'(-s7_p_reg) : P_W'(s7_p_reg);
        s8_mag_next  = MAG_W'(p_abs) << FL;
        s8_side_next = s7_side_reg;
        s8_side_next.neg = s7_p_reg[P_W-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_mag_reg  <= s8_mag_next;
            s8_den_reg  <= s7_den_reg;
            s8_side_reg <= s8_side_next;
        end
    end

    // Stage 9: detect a quotient of 2^64 or more, seed the remainder
    logic [DEN_W-1:0]   s9_rem_reg, s9_rem_next;
    logic [QB-1:0]      s9_lq_reg;
    logic [DEN_W-1:0]   s9_den_reg;
    cst_pkg::cst_side_t s9_side_reg, s9_side_next;
    logic [CMP_W-1:0]   hi_ext;

    always_comb begin
        hi_ext       = CMP_W'(s8_mag_reg[MAG_W-1:QB]);
        s9_rem_next  = hi_ext[DEN_W-1:0];
        s9_side_next = s8_side_reg;
        s9_side_next.ovf = (hi_ext >= CMP_W'(s8_den_reg));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s9_rem_reg  <= s9_rem_next;
            s9_lq_reg   <= s8_mag_reg[QB-1:0];
            s9_den_reg  <= s8_den_reg;
            s9_side_reg <= s9_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    logic               div_vld;
    cst_pkg::cst_side_t div_side;
    logic [DEN_W-1:0]   div_den;
    logic [DEN_W-1:0]   div_rem;
    logic [QB-1:0]      div_quo;

    cst_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (vld_reg[9]),
        .in_side  (s9_side_reg),
        .in_den   (s9_den_reg),
        .in_rem   (s9_rem_reg),
        .in_lq    (s9_lq_reg),
        .out_vld  (div_vld),
        .out_side (div_side),
        .out_den  (div_den),
        .out_rem  (div_rem),
        .out_quo  (div_quo)
    );

    // ------------------------------------------------------------------
    // Output stage: round half away from zero, saturate, apply sign
    logic                             m_valid_reg;
    logic [cst_pkg::IDX_W-1:0]        m_row_idx_reg, m_col_idx_reg;
    logic signed [cst_pkg::VAL_W-1:0] m_value_reg, m_value_next;
    logic                             m_degenerate_reg, m_last_reg;
    logic                             rnd_up;
    logic [QB:0]                      q_rnd;

    always_comb begin
        rnd_up = ({div_rem, 1'b0} >= {1'b0, div_den});
        q_rnd  = {1'b0, div_quo} + (QB+1)'(rnd_up);
        if (div_side.degen) begin
            m_value_next = '0;
        end else if (div_side.neg) begin
            if (div_side.ovf || (q_rnd > (QB+1)'(cst_pkg::VAL_MIN))) begin
                m_value_next = cst_pkg::VAL_MIN;
            end else begin
                m_value_next = -q_rnd[QB-1:0];
            end
        end else begin
            if (div_side.ovf || (q_rnd > (QB+1)'(cst_pkg::VAL_MAX))) begin
                m_value_next = cst_pkg::VAL_MAX;
            end else begin
                m_value_next = q_rnd[QB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && div_vld) begin
            m_row_idx_reg    <= div_side.row;
            m_col_idx_reg    <= div_side.col;
            m_value_reg      <= m_value_next;
            m_degenerate_reg <= div_side.degen;
            m_last_reg       <= div_side.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_row_idx    = m_row_idx_reg;
    assign m_col_idx    = m_col_idx_reg;
    assign m_value      = m_value_reg;
    assign m_degenerate = m_degenerate_reg;
    assign m_last       = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    `CST_ASSERT_IMP(a_degen_zero, m_valid_reg && m_degenerate_reg, m_value_reg == '0, "degenerate entry not zero")
    `CST_ASSERT_IMP(a_last_pos, m_valid_reg && m_last_reg, (m_row_idx_reg == cst_pkg::LAST_IDX) && (m_col_idx_reg == cst_pkg::LAST_IDX), "last flag off the final entry")
    `CST_ASSERT_IMP(a_ready_busy, s_ready && busy_reg, last_issue && adv, "request taken mid-matrix")
    `CST_ASSERT_NXT(a_restart, accept, busy_reg && (row_reg == '0) && (col_reg == '0), "issue counter not restarted")
endmodule
`default_nettype wire

// ===== test/triangle_element_stiffness_top_tb.sv =====
// Self-checking testbench for the triangle element stiffness block.
`timescale 1ns / 100ps
`default_nettype none
module triangle_element_stiffness_top_tb;

    typedef logic signed [255:0] wide_t;
    typedef logic [255:0]        uwide_t;

    typedef struct {
        logic signed [31:0] ax, ay, bx, by_coord, cx, cy;
        logic [30:0]        thick;
    } triangle_t;

    typedef struct {
        logic [cst_pkg::IDX_W-1:0] row, col;
        logic [cst_pkg::VAL_W-1:0] value;
        logic                      degen, last;
    } entry_t;

    localparam logic [cst_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd6;
    localparam int                            WATCHDOG_LIMIT = 3000;
    localparam int                            HOLD_CYCLES = 400;

    // Stiffness predictor and store of pending matrix entries
    class stiffness_scoreboard;
        logic signed [31:0] mat[6] = '{default: '0};
        entry_t             pending[$];
        int                 errors;
        int                 requests;

        function void set_material(int idx, logic [31:0] v);
            if (idx < 6) mat[idx] = v;
        endfunction

        function void note_request(triangle_t t);
            int     dsel[3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
            wide_t  x13, y13, x23, y23, x12, y12, det, acc, th;
            wide_t  bn[3][6];
            wide_t  s[3][6];
            uwide_t den, mag, q;
            entry_t e;
            logic   neg;
            requests++;
            x12 = wide_t'(t.ax) - wide_t'(t.bx);
            y12 = wide_t'(t.ay) - wide_t'(t.by_coord);
            x13 = wide_t'(t.ax) - wide_t'(t.cx);
            y13 = wide_t'(t.ay) - wide_t'(t.cy);
            x23 = wide_t'(t.bx) - wide_t'(t.cx);
            y23 = wide_t'(t.by_coord) - wide_t'(t.cy);
            bn[0] = '{y23, 0, -y13, 0, y12, 0};
            bn[1] = '{0, -x23, 0, x13, 0, -x12};
            bn[2] = '{-x23, y23, x13, -y13, -x12, y12};
            det = x13 * y23 - x23 * y13;
            den = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
            den = den << 1;
            th = wide_t'({225'b0, t.thick});
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 6; j++) begin
                    s[i][j] = 0;
                    for (int k = 0; k < 3; k++)
                        s[i][j] += wide_t'(mat[dsel[i][k]]) * bn[k][j];
                end
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 6; j++) begin
                    e.row = cst_pkg::IDX_W'(i);
                    e.col = cst_pkg::IDX_W'(j);
                    e.degen = (det == 0);
                    e.last = (i == 5 && j == 5);
                    e.value = '0;
                    if (det != 0) begin
                        acc = 0;
                        for (int k = 0; k < 3; k++) acc += bn[k][i] * s[k][j];
                        acc = acc * th;
                        neg = acc < 0;
                        mag = neg ? uwide_t'(-acc) : uwide_t'(acc);
                        // round half away from zero, then saturate
                        q = (2 * mag + den) / (2 * den);
                        if (neg) e.value = (q > uwide_t'(cst_pkg::VAL_MIN)) ?
                                           cst_pkg::VAL_MIN : -q[63:0];
                        else e.value = (q > uwide_t'(cst_pkg::VAL_MAX)) ?
                                       cst_pkg::VAL_MAX : q[63:0];
                    end
                    pending = {pending, e};
                end
        endfunction

        function void check_entry(entry_t got);
            entry_t want;
            if (pending.size() == 0) begin
                $error("unexpected entry row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.row !== want.row) begin
                $error("row_idx exp %0d got %0d", want.row, got.row); errors++;
            end
            if (got.col !== want.col) begin
                $error("col_idx exp %0d got %0d", want.col, got.col); errors++;
            end
            if (got.value !== want.value) begin
                $error("value exp %h got %h", want.value, got.value); errors++;
            end
            if (got.degen !== want.degen) begin
                $error("degenerate exp %0b got %0b", want.degen, got.degen); errors++;
            end
            if (got.last !== want.last) begin
                $error("last exp %0b got %0b", want.last, got.last); errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready;
    logic signed [31:0] s_ax = 0, s_ay = 0, s_bx = 0, s_by_coord = 0, s_cx = 0, s_cy = 0;
    logic [30:0] s_thick = 0;
    logic m_valid, m_ready = 0;
    logic [cst_pkg::IDX_W-1:0] m_row_idx, m_col_idx;
    logic signed [cst_pkg::VAL_W-1:0] m_value;
    logic m_degenerate, m_last;
    logic cfg_wr_en = 0;
    logic [cst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cst_pkg::D_W-1:0] cfg_wdata = '0;

    stiffness_scoreboard sb = new();
    int  cycle_cnt = 0, hold_left = 0, idle_cycles = 0;
    bit  held = 0;

    triangle_element_stiffness_top dut (.*);

    initial forever #5 aclk = ~aclk;

    // no idling in the first part of each repeating window of cycle_cnt
    function automatic bit take_break();
        return ((cycle_cnt % 4000) >= 800) && ($urandom_range(99) < 21);
    endfunction

    always @(posedge aclk) begin
        cycle_cnt++;
        idle_cycles = ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : idle_cycles + 1;
        if (aresetn && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive the result side ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!held && sb.requests >= 100) begin
            held = 1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !take_break();
        end
    end

    // Check each accepted matrix entry
    always @(posedge aclk) begin
        entry_t got;
        if (aresetn && m_valid && m_ready) begin
            got.row = m_row_idx;
            got.col = m_col_idx;
            got.value = m_value;
            got.degen = m_degenerate;
            got.last = m_last;
            sb.check_entry(got);
        end
    end

    task automatic send_request(triangle_t t);
        if (take_break()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (take_break());
        end
        s_valid <= 1'b1;
        s_ax <= t.ax; s_ay <= t.ay; s_bx <= t.bx;
        s_by_coord <= t.by_coord; s_cx <= t.cx; s_cy <= t.cy;
        s_thick <= t.thick;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(t);
    endtask

    // Drain, let the pipeline settle, then load a material matrix
    task automatic load_material(logic [31:0] v[6]);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cst_pkg::cfg_reg_t'(i);
            cfg_wdata <= v[i];
            @(posedge aclk);
            sb.set_material(i, v[i]);
        end
        // spare index must leave the matrix alone
        cfg_index <= CFG_SPARE_IDX;
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [31:0] coord(bit wide_range);
        if (wide_range) return $urandom;
        return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        bit w = $urandom_range(9) < 2;
        t.ax = coord(w); t.ay = coord(w); t.bx = coord(w);
        t.by_coord = coord(w); t.cx = coord(w); t.cy = coord(w);
        t.thick = w ? 31'($urandom) : 31'($urandom_range(1, 1 << 18));
        // now and then a collinear or coincident triangle
        if ($urandom_range(19) == 0) begin
            t.cx = t.bx; t.cy = t.by_coord;
        end
        return t;
    endfunction

    function automatic logic [31:0] random_d();
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom_range(0, 1 << 20)) - (1 << 18);
    endfunction

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) send_request(random_triangle());
    endtask

    initial begin
        logic [31:0] dv[6];
        triangle_t   t;
        logic signed [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero material after reset
        send_request('{0, 0, 32'sh10000, 0, 0, 32'sh10000, 31'h10000});
        run_random(10);

        // isotropic-like material, directed cases
        dv = '{32'd51200, 32'd15360, 32'd0, 32'd51200, 32'd0, 32'd17920};
        load_material(dv);
        send_request('{0, 0, 32'sh10000, 0, 0, 32'sh10000, 31'h10000});
        send_request('{0, 0, 0, 32'sh10000, 32'sh10000, 0, 31'h10000});
        send_request('{5, 5, 5, 5, 5, 5, 31'h10000});
        send_request('{0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 31'h10000});
        send_request('{0, 0, 32'sh10000, 0, 0, 32'sh10000, 31'h0});
        send_request('{0, 0, 32'sh10000, 0, 0, 32'sh10000, 31'h7FFF_FFFF});
        send_request('{mx, mx, mn, mx, mx, mn, 31'h7FFF_FFFF});
        send_request('{mn, mn, mx, mn, mn, mx, 31'h7FFF_FFFF});
        send_request('{mn, mx, mx, mn, 0, 0, 31'h1});
        send_request('{0, 0, 1, 0, 0, 1, 31'h7FFF_FFFF});
        send_request('{-1, -1, 0, -1, -1, 0, 31'h1});
        send_request('{mx, mx, mx, mx, mx, mx, 31'h7FFF_FFFF});
        send_request('{32'sh30000, -32'sh20000, -32'sh10000, 32'sh40000,
                       32'sh8000, 32'sh18000, 31'h18000});
        run_random(170);

        // extreme material entries
        dv = '{mx, mx, mx, mx, mx, mx};
        load_material(dv);
        send_request('{mx, mx, mn, mx, mx, mn, 31'h7FFF_FFFF});
        run_random(40);
        dv = '{mn, mn, mn, mn, mn, mn};
        load_material(dv);
        send_request('{mn, mx, mx, mn, 0, 0, 31'h7FFF_FFFF});
        run_random(40);

        // random materials
        for (int p = 0; p < 4; p++) begin
            foreach (dv[i]) dv[i] = random_d();
            load_material(dv);
            run_random(45);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== triangle_element_stiffness_top.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_div.sv
rtl/triangle_element_stiffness_top.sv
test/triangle_element_stiffness_top_tb.sv
